// ----- rtl/dda_pkg.sv -----
`default_nettype none

package dda_pkg;

   // request kind carried on req_tuser
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // sequencer states
   localparam int STATE_BITS = 2;
   typedef logic [STATE_BITS-1:0] state_type;
   localparam state_type ST_IDLE  = 2'd0;
   localparam state_type ST_DIV_X = 2'd1;
   localparam state_type ST_DIV_Y = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/dda_line_rasterizer.sv -----
`default_nettype none

// DDA line rasterizer. A load request (req_tuser = 0) latches a start and an
// end point; the block then runs one shared restoring divider twice, first for
// the x increment and then for the y increment, and keeps req_tready low while
// the divider runs. A zero-length line skips the divider. A step request
// (req_tuser = 1) places the rounded accumulators into the output register and
// advances them, so steps stream at one per cycle while the output side keeps
// up. A line gives max(|dx|,|dy|)+1 pixels, the last one being the end point
// with rsp_tlast high. A step with no line loaded, or after the last pixel, is
// taken and gives no output.
module dda_line_rasterizer
   import dda_pkg::*;
#(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic clock,
   input  wire logic reset,

   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // x_start, y_start, x_end, y_end (lowest bits first), zero padded
   input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   // op
   input  wire logic                                   req_tuser,

   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // pixel_x, pixel_y (lowest bits first), zero padded
   output logic [((2*COORD_BITS+7)/8)*8-1:0]           rsp_tdata,
   output logic                                        rsp_tlast
);

   localparam int ACC_BITS  = COORD_BITS + FRAC_BITS + 1;
   localparam int INC_BITS  = FRAC_BITS + 2;
   localparam int QUO_BITS  = FRAC_BITS + 1;
   localparam int STEP_BITS = COORD_BITS + 1;
   localparam int CNT_BITS  = $clog2(FRAC_BITS + 1);
   localparam int OUT_BITS  = ((2*COORD_BITS+7)/8)*8;
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS);
   localparam logic [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

   // request fields
   logic [COORD_BITS-1:0] x_start, y_start, x_end, y_end;
   assign x_start = req_tdata[COORD_BITS-1:0];
   assign y_start = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign x_end   = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign y_end   = req_tdata[4*COORD_BITS-1:3*COORD_BITS];

   // state
   state_type             state_ff, state_in;
   logic [ACC_BITS-1:0]   x_accum_ff, x_accum_in, y_accum_ff, y_accum_in;
   logic [INC_BITS-1:0]   x_inc_ff, x_inc_in, y_inc_ff, y_inc_in;
   logic [STEP_BITS-1:0]  steps_left_ff, steps_left_in;
   logic                  line_active_ff, line_active_in;
   // divider
   logic [COORD_BITS-1:0] len_ff, len_in, ady_ff, ady_in;
   logic                  neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [COORD_BITS:0]   rem_ff, rem_in;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic                  last_ff, last_in;

   logic req_fire;
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   // endpoint deltas for a load
   logic                  ld_neg_x, ld_neg_y;
   logic [COORD_BITS-1:0] ld_adx, ld_ady, ld_len;
   always_comb begin
      ld_neg_x = x_end < x_start;
      ld_neg_y = y_end < y_start;
      ld_adx   = ld_neg_x ? (x_start - x_end) : (x_end - x_start);
      ld_ady   = ld_neg_y ? (y_start - y_end) : (y_end - y_start);
      ld_len   = (ld_adx > ld_ady) ? ld_adx : ld_ady;
   end

   // one restoring division step; the first step holds the integer bit
   logic [COORD_BITS:0]  rem_sh, rem_nx;
   logic                 geq;
   logic [QUO_BITS-1:0]  quo_nx;
   logic                 div_neg;
   logic [INC_BITS-1:0]  div_inc;
   always_comb begin
      rem_sh  = (cnt_ff == '0) ? rem_ff : {rem_ff[COORD_BITS-1:0], 1'b0};
      geq     = rem_sh >= {1'b0, len_ff};
      rem_nx  = geq ? (rem_sh - {1'b0, len_ff}) : rem_sh;
      quo_nx  = {quo_ff[QUO_BITS-2:0], geq};
      div_neg = (state_ff == ST_DIV_X) ? neg_x_ff : neg_y_ff;
      div_inc = div_neg ? (INC_BITS'(0) - {1'b0, quo_nx}) : {1'b0, quo_nx};
   end

   // rounded pixel from each accumulator
   logic [ACC_BITS-1:0] x_round, y_round;
   always_comb begin
      x_round = x_accum_ff + HALF;
      y_round = y_accum_ff + HALF;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      x_accum_in     = x_accum_ff;
      y_accum_in     = y_accum_ff;
      x_inc_in       = x_inc_ff;
      y_inc_in       = y_inc_ff;
      steps_left_in  = steps_left_ff;
      line_active_in = line_active_ff;
      len_in         = len_ff;
      ady_in         = ady_ff;
      neg_x_in       = neg_x_ff;
      neg_y_in       = neg_y_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      pix_x_in       = pix_x_ff;
      pix_y_in       = pix_y_ff;
      last_in        = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_tuser == OP_LOAD) begin
               x_accum_in     = {1'b0, x_start, FRAC_BITS'(0)};
               y_accum_in     = {1'b0, y_start, FRAC_BITS'(0)};
               steps_left_in  = {1'b0, ld_len} + STEP_BITS'(1);
               line_active_in = 1'b1;
               len_in         = ld_len;
               ady_in         = ld_ady;
               neg_x_in       = ld_neg_x;
               neg_y_in       = ld_neg_y;
               rem_in         = {1'b0, ld_adx};
               quo_in         = '0;
               cnt_in         = '0;
               x_inc_in       = '0;
               y_inc_in       = '0;
               if (ld_len != '0) begin
                  state_in = ST_DIV_X;
               end
            end else if (req_fire) begin
               if (!line_active_ff || steps_left_ff == '0) begin
                  line_active_in = 1'b0;
               end else begin
                  rsp_valid_in  = 1'b1;
                  pix_x_in      = x_round[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
                  pix_y_in      = y_round[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
                  last_in       = steps_left_ff == STEP_BITS'(1);
                  x_accum_in    = x_accum_ff
                                + {{(ACC_BITS-INC_BITS){x_inc_ff[INC_BITS-1]}}, x_inc_ff};
                  y_accum_in    = y_accum_ff
                                + {{(ACC_BITS-INC_BITS){y_inc_ff[INC_BITS-1]}}, y_inc_ff};
                  steps_left_in = steps_left_ff - STEP_BITS'(1);
                  if (steps_left_ff == STEP_BITS'(1)) begin
                     line_active_in = 1'b0;
                  end
               end
            end
         end
         ST_DIV_X: begin
            rem_in = rem_nx;
            quo_in = quo_nx;
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_LAST) begin
               x_inc_in = div_inc;
               rem_in   = {1'b0, ady_ff};
               quo_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            rem_in = rem_nx;
            quo_in = quo_nx;
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_LAST) begin
               y_inc_in = div_inc;
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         x_accum_ff     <= '0;
         y_accum_ff     <= '0;
         x_inc_ff       <= '0;
         y_inc_ff       <= '0;
         steps_left_ff  <= '0;
         line_active_ff <= 1'b0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         x_accum_ff     <= x_accum_in;
         y_accum_ff     <= y_accum_in;
         x_inc_ff       <= x_inc_in;
         y_inc_ff       <= y_inc_in;
         steps_left_ff  <= steps_left_in;
         line_active_ff <= line_active_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      ady_ff   <= ady_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      pix_x_ff <= pix_x_in;
      pix_y_ff <= pix_y_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_BITS'({pix_y_ff, pix_x_ff});
   assign rsp_tlast  = last_ff;

   // checks
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request taken while divider busy");

   a_step_gives_pixel: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == OP_STEP && line_active_ff && steps_left_ff != '0)
      |=> rsp_valid_ff)
      else $error("active step produced no pixel");

   a_load_divides: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == OP_LOAD && ld_len != '0) |=> (state_ff == ST_DIV_X))
      else $error("load did not start the divider");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_X || state_ff == ST_DIV_Y) |-> (cnt_ff <= CNT_LAST))
      else $error("divider count out of range");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == OP_STEP && line_active_ff && steps_left_ff == STEP_BITS'(1))
      |=> (rsp_tlast && !line_active_ff))
      else $error("end point not marked last");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
   import dda_pkg::*;
();

   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 16;
   localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
   localparam int SLOPE_BITS = FRAC_BITS + 2;
   localparam int COUNT_BITS = COORD_BITS + 1;
   localparam int REQ_BITS   = ((4*COORD_BITS+7)/8)*8;
   localparam int RSP_BITS   = ((2*COORD_BITS+7)/8)*8;
   localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

   localparam int ITEM_TARGET   = 1550;
   localparam int HOLD_CYCLES   = 300;
   localparam int WATCHDOG_MAX  = 3000;
   localparam int SETTLE_CYCLES = 2*FRAC_BITS + 8;
   localparam int REPORT_MAX    = 30;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata  = '0;
   logic                req_tuser  = OP_LOAD;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                rsp_tlast;

   // line tracker state
   logic [ACC_BITS-1:0]          x_pos, y_pos;
   logic signed [SLOPE_BITS-1:0] x_slope, y_slope;
   logic [COUNT_BITS-1:0]        pixels_left;
   logic                         drawing;

   pixel_type expected_pixels[$];

   bit idling_on        = 1'b1;
   bit hold_off_request = 1'b0;
   int stall_left       = 0;
   int error_count      = 0;
   int items_sent       = 0;
   int loads_sent       = 0;
   int dead_steps       = 0;
   int pixels_checked   = 0;
   int quiet_cycles     = 0;

   dda_line_rasterizer #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #1 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // signed per-step increment, truncated toward zero
   function automatic logic [SLOPE_BITS-1:0] slope_of(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b,
                                                      input logic [COUNT_BITS-1:0] len);
      logic [COORD_BITS-1:0] delta;
      logic [SLOPE_BITS-1:0] mag;
      if (len == '0) return '0;
      delta = (b < a) ? a - b : b - a;
      mag   = SLOPE_BITS'({delta, {FRAC_BITS{1'b0}}} / len);
      if (b < a) mag = -mag;
      return mag;
   endfunction

   // rounds an accumulator to the nearest pixel
   function automatic logic [COORD_BITS-1:0] round_pos(input logic [ACC_BITS-1:0] acc);
      logic [ACC_BITS-1:0] sum;
      sum = acc + (ACC_BITS'(1) << (FRAC_BITS - 1));
      return sum[FRAC_BITS +: COORD_BITS];
   endfunction

   // advances the line tracker by one request; returns 1 when a pixel comes out
   function automatic bit rasterize_request(input logic op,
                                            input logic [COORD_BITS-1:0] xs,
                                            input logic [COORD_BITS-1:0] ys,
                                            input logic [COORD_BITS-1:0] xe,
                                            input logic [COORD_BITS-1:0] ye,
                                            output pixel_type px);
      logic [COUNT_BITS-1:0] adx, ady, len;
      px = '0;
      if (op == OP_LOAD) begin
         adx = COUNT_BITS'((xe > xs) ? xe - xs : xs - xe);
         ady = COUNT_BITS'((ye > ys) ? ye - ys : ys - ye);
         len = (adx > ady) ? adx : ady;
         x_slope     = slope_of(xs, xe, len);
         y_slope     = slope_of(ys, ye, len);
         x_pos       = ACC_BITS'(xs) << FRAC_BITS;
         y_pos       = ACC_BITS'(ys) << FRAC_BITS;
         pixels_left = len + 1'b1;
         drawing     = 1'b1;
         return 1'b0;
      end
      if (!drawing || pixels_left == '0) begin
         drawing = 1'b0;
         return 1'b0;
      end
      px.x    = round_pos(x_pos);
      px.y    = round_pos(y_pos);
      px.last = (pixels_left == COUNT_BITS'(1));
      x_pos = x_pos + {{(ACC_BITS-SLOPE_BITS){x_slope[SLOPE_BITS-1]}}, x_slope};
      y_pos = y_pos + {{(ACC_BITS-SLOPE_BITS){y_slope[SLOPE_BITS-1]}}, y_slope};
      pixels_left = pixels_left - 1'b1;
      if (pixels_left == '0) drawing = 1'b0;
      return 1'b1;
   endfunction

   // offers one request and waits for it to be taken
   task automatic send_request(input logic op,
                               input logic [COORD_BITS-1:0] xs,
                               input logic [COORD_BITS-1:0] ys,
                               input logic [COORD_BITS-1:0] xe,
                               input logic [COORD_BITS-1:0] ye);
      int        gap;
      pixel_type px;
      gap = idling_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {ye, xe, ys, xs};
      do @(posedge clock); while (!req_tready);
      if (rasterize_request(op, xs, ys, xe, ye, px)) expected_pixels.push_back(px);
      else if (op == OP_STEP) dead_steps++;
      if (op == OP_LOAD) loads_sent++;
      items_sent++;
   endtask

   task automatic send_step();
      send_request(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                   COORD_BITS'($urandom), COORD_BITS'($urandom));
   endtask

   // sender goes quiet until every pixel is back
   task automatic wait_for_pixels();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   // end coordinate within span of the start, kept on screen
   function automatic int pick_end(input int s, input int span);
      int d;
      d = $urandom_range(0, span);
      if ($urandom_range(0, 1)) d = -d;
      if (s + d < 0 || s + d > COORD_MAX) d = -d;
      return s + d;
   endfunction

   // steps before any line is loaded
   task automatic test_steps_without_line();
      send_step();
      send_step();
   endtask

   // hand-picked lines: point, screen corners, replace mid-line, both slopes
   task automatic test_directed_lines();
      send_request(OP_LOAD, COORD_BITS'(COORD_MAX), 0, COORD_BITS'(COORD_MAX), 0);
      send_step();
      send_step();
      send_request(OP_LOAD, 0, COORD_BITS'(COORD_MAX), COORD_BITS'(COORD_MAX), 0);
      send_step();
      send_step();
      send_request(OP_LOAD, 7, 3, 4, 5);
      repeat (5) send_step();
      send_request(OP_LOAD, 2, 9, 4, 2);
      repeat (8) send_step();
   endtask

   // output held off long enough for the block to back up into its input
   task automatic test_back_pressure();
      int xs, ys;
      idling_on = 1'b0;
      xs = $urandom_range(0, 400);
      ys = $urandom_range(100, 900);
      hold_off_request = 1'b1;
      send_request(OP_LOAD, COORD_BITS'(xs), COORD_BITS'(ys),
                   COORD_BITS'(xs + 60), COORD_BITS'(ys - 23));
      repeat (61) send_step();
      wait_for_pixels();
      idling_on = 1'b1;
   endtask

   // random lines: mostly complete, some cut short, overrun or wild
   task automatic test_random_lines();
      int line_no, kind, span, count, len, xs, ys, xe, ye;
      line_no = 0;
      while (items_sent < ITEM_TARGET) begin
         if (line_no % 16 == 0) idling_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 99);
         span = (kind < 68) ? 12 : (kind < 93) ? 60 : 300;
         xs = $urandom_range(0, COORD_MAX);
         ys = $urandom_range(0, COORD_MAX);
         xe = pick_end(xs, span);
         ye = pick_end(ys, span);
         if (kind >= 97) begin
            xe = $urandom_range(0, COORD_MAX);
            ye = $urandom_range(0, COORD_MAX);
         end
         len = (xe > xs ? xe - xs : xs - xe);
         if ((ye > ys ? ye - ys : ys - ye) > len) len = (ye > ys ? ye - ys : ys - ye);
         send_request(OP_LOAD, COORD_BITS'(xs), COORD_BITS'(ys),
                      COORD_BITS'(xe), COORD_BITS'(ye));
         count = $urandom_range(0, 99);
         if (kind >= 97)     count = $urandom_range(0, 6);
         else if (count < 75) count = len + 1;
         else if (count < 88) count = $urandom_range(0, len);
         else                 count = len + 1 + $urandom_range(1, 3);
         repeat (count) send_step();
         if ($urandom_range(0, 19) == 0) wait_for_pixels();
         line_no++;
      end
      idling_on = 1'b1;
   endtask

   // output side: random stalls, plus one long hold-off on request
   always begin
      @(negedge clock);
      if (hold_off_request) begin
         rsp_tready <= 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
         rsp_tready <= 1'b1;
         hold_off_request = 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (idling_on) stall_left = pick_gap();
      end
   end

   // pixel checker
   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x    = rsp_tdata[COORD_BITS-1:0];
         got.y    = rsp_tdata[2*COORD_BITS-1:COORD_BITS];
         got.last = rsp_tlast;
         if (expected_pixels.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("%0t: unexpected pixel x=%0d y=%0d last=%0b",
                        $time, got.x, got.y, got.last);
         end else begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (got !== want) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("%0t: pixel mismatch exp x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                           $time, want.x, want.y, want.last, got.x, got.y, got.last);
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("%0t: no handshake for %0d cycles, %0d pixels outstanding",
                  $time, quiet_cycles, expected_pixels.size());
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      x_pos       = '0;
      y_pos       = '0;
      x_slope     = '0;
      y_slope     = '0;
      pixels_left = '0;
      drawing     = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_steps_without_line();
      test_directed_lines();
      test_back_pressure();
      test_random_lines();

      wait_for_pixels();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d line loads, %0d steps with no line active).",
               items_sent, loads_sent, dead_steps);
      $display("Checked %0d pixels, with one long output hold-off and random stalls.",
               pixels_checked);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
